@@ rtl/ptss_pkg.sv @@
// Package for the PPS time sync sequencer: register indexes, phase encoding,
// channel payload types and small helper functions.
// Has no dependencies; every other file of the block uses it.
package ptss_pkg;

	localparam int unsigned CNT_W      = 16;
	localparam int unsigned SEC_W      = 12;
	localparam int unsigned OFFS_NS_W  = 42;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [OFFS_NS_W-1:0] NS_PER_SECOND = OFFS_NS_W'(1000000000);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STARTUP_WAIT   = 3'd0,
		CFG_OFFSET_WAIT    = 3'd1,
		CFG_SYNC_PERIOD    = 3'd2,
		CFG_DYN_OFFSET_EN  = 3'd3,
		CFG_DEFAULT_OFFSET = 3'd4,
		CFG_STATIC_OFFSET  = 3'd5,
		CFG_PPS_LEVEL      = 3'd6,
		CFG_CHECK_VALID    = 3'd7
	} cfg_idx_t;

	typedef enum logic [4:0] {
		PH_INIT      = 5'b00001,
		PH_ACQUIRE   = 5'b00010,
		PH_SYNC_WAIT = 5'b00100,
		PH_SENT      = 5'b01000,
		PH_FAILED    = 5'b10000
	} phase_t;

	localparam logic [2:0] SYNC_INIT      = 3'd0;
	localparam logic [2:0] SYNC_ACQUIRE   = 3'd1;
	localparam logic [2:0] SYNC_WAIT      = 3'd2;
	localparam logic [2:0] SYNC_SENT      = 3'd3;
	localparam logic [2:0] SYNC_FAILED    = 3'd4;

	typedef struct packed {
		logic        time_base_valid;
		logic [63:0] now_ns;
		logic        measured_offset_ok;
		logic [63:0] measured_offset_ns;
	} tick_t;

	typedef struct packed {
		logic        pps_level;
		logic        msg_valid;
		logic [63:0] msg_time_ns;
		logic [7:0]  msg_checksum;
		logic [7:0]  msg_sequence;
		logic [2:0]  sync_state;
		logic [63:0] active_offset_ns;
	} result_t;

	function automatic logic [2:0] phase_code(phase_t ph);
		logic [2:0] code;
		case (ph)
			PH_INIT:      code = SYNC_INIT;
			PH_ACQUIRE:   code = SYNC_ACQUIRE;
			PH_SYNC_WAIT: code = SYNC_WAIT;
			PH_SENT:      code = SYNC_SENT;
			PH_FAILED:    code = SYNC_FAILED;
			default:      code = SYNC_INIT;
		endcase
		return code;
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
		return (&v) ? v : v + CNT_W'(1);
	endfunction

	function automatic logic [7:0] byte_sum(logic [63:0] v);
		logic [7:0] s;
		s = 8'd0;
		for (int k = 0; k < 8; k++) begin
			s = s + v[8*k +: 8];
		end
		return s;
	endfunction

	function automatic logic [OFFS_NS_W-1:0] sec_to_ns(logic [SEC_W-1:0] sec);
		return OFFS_NS_W'(sec) * NS_PER_SECOND;
	endfunction

endpackage

@@ rtl/ptss_ifs.sv @@
// Channel interfaces of the PPS time sync sequencer: tick input, result
// output and configuration write port. Depends on ptss_pkg.
interface ptss_tick_if;
	logic           valid;
	logic           ready;
	ptss_pkg::tick_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface ptss_result_if;
	logic              valid;
	logic              ready;
	ptss_pkg::result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface ptss_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [ptss_pkg::CFG_IDX_W-1:0]      index;
	logic [ptss_pkg::CFG_DATA_W-1:0]     data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

@@ rtl/pps_time_sync_sequencer_unit.sv @@
// Top level of the PPS time sync sequencer: tick register, sequencer state,
// result register and configuration registers. Depends on ptss_pkg, ptss_ifs.
//
// Channel  Dir  Payload
// tick     in   time_base_valid, now_ns, measured_offset_ok, measured_offset_ns
// result   out  pps_level, msg_valid, msg_time_ns, msg_checksum, msg_sequence,
//               sync_state, active_offset_ns
// cfg      in   index, data (always ready)
//
// Each item passes through the tick register and then the result register, and one
// item is taken per cycle while the result side is not stalled.
// The sequencer state is updated as an item moves into the result register.
// A stalled result holds the tick register, and the tick side stalls only when both are full.
// Reset clears the sequencer to its init phase and loads the register defaults.
module pps_time_sync_sequencer_unit (
	input  logic        clk,
	input  logic        arst_n,
	ptss_tick_if.sink   tick,
	ptss_result_if.source result,
	ptss_cfg_if.sink    cfg
);
	import ptss_pkg::*;

	logic [CNT_W-1:0]     startup_wait_q;
	logic [CNT_W-1:0]     offset_wait_q;
	logic [CNT_W-1:0]     sync_period_q;
	logic                 dyn_offset_en_q;
	logic [OFFS_NS_W-1:0] default_offset_ns_q;
	logic [OFFS_NS_W-1:0] static_offset_ns_q;
	logic                 pps_active_level_q;
	logic                 check_valid_q;

	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] startup_cnt_q, startup_cnt_d;
	logic [CNT_W-1:0] offset_wait_cnt_q, offset_wait_cnt_d;
	logic [CNT_W-1:0] period_cnt_q, period_cnt_d;
	logic [63:0]      offset_q, offset_d;
	logic [7:0]       seq_q, seq_d;
	logic             pps_asserted_q, pps_asserted_d;

	logic    valid_s1;
	tick_t   tick_s1;
	logic    res_valid_q;
	result_t res_q, res_d;
	logic    advance;
	logic    step_en;
	logic [CNT_W-1:0] period_inc;
	logic [63:0]      msg_time;
	logic             time_ok;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			startup_wait_q      <= CNT_W'(100);
			offset_wait_q       <= CNT_W'(50);
			sync_period_q       <= CNT_W'(100);
			dyn_offset_en_q     <= 1'b1;
			default_offset_ns_q <= '0;
			static_offset_ns_q  <= '0;
			pps_active_level_q  <= 1'b1;
			check_valid_q       <= 1'b1;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				CFG_STARTUP_WAIT:   startup_wait_q <= cfg.data[CNT_W-1:0];
				CFG_OFFSET_WAIT:    offset_wait_q <= cfg.data[CNT_W-1:0];
				CFG_SYNC_PERIOD:    sync_period_q <= cfg.data[CNT_W-1:0];
				CFG_DYN_OFFSET_EN:  dyn_offset_en_q <= cfg.data[0];
				CFG_DEFAULT_OFFSET: default_offset_ns_q <= sec_to_ns(cfg.data[SEC_W-1:0]);
				CFG_STATIC_OFFSET:  static_offset_ns_q <= sec_to_ns(cfg.data[SEC_W-1:0]);
				CFG_PPS_LEVEL:      pps_active_level_q <= cfg.data[0];
				CFG_CHECK_VALID:    check_valid_q <= cfg.data[0];
				default:            ;
			endcase
		end
	end

	assign advance    = !res_valid_q || result.ready;
	assign tick.ready = !valid_s1 || advance;
	assign step_en    = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			tick_s1 <= tick.data;
		end
	end

	assign period_inc = sat_inc(period_cnt_q);
	assign msg_time   = tick_s1.now_ns + offset_q;
	assign time_ok    = !check_valid_q || tick_s1.time_base_valid;

	always_comb begin
		phase_d           = phase_q;
		startup_cnt_d     = startup_cnt_q;
		offset_wait_cnt_d = offset_wait_cnt_q;
		period_cnt_d      = period_cnt_q;
		offset_d          = offset_q;
		seq_d             = seq_q;
		pps_asserted_d    = pps_asserted_q;
		res_d             = '0;
		case (phase_q)
			PH_INIT: begin
				seq_d   = '0;
				phase_d = PH_ACQUIRE;
			end
			PH_ACQUIRE: begin
				startup_cnt_d = sat_inc(startup_cnt_q);
				if (startup_cnt_q >= startup_wait_q) begin
					if (dyn_offset_en_q) begin
						offset_wait_cnt_d = sat_inc(offset_wait_cnt_q);
						if (offset_wait_cnt_q >= offset_wait_q) begin
							offset_d = 64'(default_offset_ns_q);
							phase_d  = PH_SYNC_WAIT;
						end else if (tick_s1.measured_offset_ok) begin
							offset_d = tick_s1.measured_offset_ns;
							phase_d  = PH_SYNC_WAIT;
						end
					end else begin
						offset_d = 64'(static_offset_ns_q);
						phase_d  = PH_SYNC_WAIT;
					end
				end
			end
			PH_SYNC_WAIT: begin
				period_cnt_d = period_inc;
				if (period_inc >= sync_period_q) begin
					period_cnt_d = '0;
					if (time_ok) begin
						pps_asserted_d     = 1'b1;
						res_d.msg_valid    = 1'b1;
						res_d.msg_time_ns  = msg_time;
						res_d.msg_checksum = byte_sum(msg_time);
						res_d.msg_sequence = seq_q;
						seq_d              = seq_q + 8'd1;
						phase_d            = PH_SENT;
					end else begin
						phase_d = PH_FAILED;
					end
				end
			end
			PH_SENT: begin
				pps_asserted_d = 1'b0;
				period_cnt_d   = period_inc;
				phase_d        = PH_SYNC_WAIT;
			end
			PH_FAILED: begin
				phase_d = PH_SYNC_WAIT;
			end
			default: ;
		endcase
		res_d.pps_level        = pps_asserted_d ? pps_active_level_q : !pps_active_level_q;
		res_d.sync_state       = phase_code(phase_d);
		res_d.active_offset_ns = offset_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= PH_INIT;
			startup_cnt_q     <= '0;
			offset_wait_cnt_q <= '0;
			period_cnt_q      <= '0;
			offset_q          <= '0;
			seq_q             <= '0;
			pps_asserted_q    <= 1'b0;
			res_valid_q       <= 1'b0;
		end else begin
			if (advance) begin
				res_valid_q <= valid_s1;
			end
			if (step_en) begin
				phase_q           <= phase_d;
				startup_cnt_q     <= startup_cnt_d;
				offset_wait_cnt_q <= offset_wait_cnt_d;
				period_cnt_q      <= period_cnt_d;
				offset_q          <= offset_d;
				seq_q             <= seq_d;
				pps_asserted_q    <= pps_asserted_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_q <= res_d;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	// The pulse is held exactly while the sequencer sits in its sent phase.
	a_pps_in_sent: assert property (@(posedge clk) disable iff (!arst_n)
		pps_asserted_q == (phase_q == PH_SENT))
		else $error("PPS flag and sent phase disagree");

	// A message is only ever reported together with the sent state.
	a_msg_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.msg_valid |-> res_q.sync_state == SYNC_SENT)
		else $error("message without sent state");

	// Results without a message carry zero message fields.
	a_no_msg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.msg_valid |->
		res_q.msg_time_ns == '0 && res_q.msg_checksum == '0 && res_q.msg_sequence == '0)
		else $error("message fields set without a message");

	// Each emitted message advances the sequence number by one.
	a_seq_step: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res_d.msg_valid |=> seq_q == $past(seq_q) + 8'd1)
		else $error("sequence number did not advance");

	// A stalled item never updates the sequencer state.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step_en |=> $stable(phase_q) && $stable(seq_q) && $stable(offset_q))
		else $error("sequencer state changed without an item");

endmodule

@@ bench/pps_time_sync_sequencer_unit_tb.sv @@
// Testbench for pps_time_sync_sequencer_unit: drives scheduler ticks and register
// writes, predicts every result with its own sequencer model and checks each field.
// Depends on ptss_pkg and the channel interfaces in ptss_ifs.
module pps_time_sync_sequencer_unit_tb;
	import ptss_pkg::*;

	localparam logic [63:0] NS_PER_SEC = 64'd1000000000;
	localparam int unsigned CYCLE_LIMIT = 1000000;

	logic clk;
	logic arst_n;

	ptss_tick_if   tick_ch();
	ptss_result_if result_ch();
	ptss_cfg_if    cfg_ch();

	pps_time_sync_sequencer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tick_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	// Register copies, at their reset values.
	logic [15:0] reg_startup_wait = 16'd100;
	logic [15:0] reg_offset_wait  = 16'd50;
	logic [15:0] reg_sync_period  = 16'd100;
	logic        reg_dyn_offset   = 1'b1;
	logic [11:0] reg_default_sec  = 12'd0;
	logic [11:0] reg_static_sec   = 12'd0;
	logic        reg_pps_level    = 1'b1;
	logic        reg_check_valid  = 1'b1;

	// Sequencer state copies.
	logic [2:0]  seq_phase   = SYNC_INIT;
	logic [15:0] startup_cnt = '0;
	logic [15:0] owait_cnt   = '0;
	logic [15:0] period_cnt  = '0;
	logic [63:0] offset_ns   = '0;
	logic [7:0]  seq_num     = '0;
	logic        pps_on      = 1'b0;

	tick_t       pending_ticks[$];
	result_t     results_due[$];
	int          ticks_outstanding = 0;
	int unsigned tick_gap = 0;
	int unsigned ready_stall = 0;
	bit          gaps_on = 1'b0;
	bit          tick_fired = 1'b0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;

	function automatic logic [15:0] sat16(logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic logic [63:0] seconds_to_ns(logic [11:0] sec);
		return 64'(sec) * NS_PER_SEC;
	endfunction

	function automatic result_t advance_sequencer(tick_t t);
		result_t     r;
		logic [15:0] prev;
		r = '0;
		case (seq_phase)
			SYNC_INIT: begin
				seq_num = '0;
				seq_phase = SYNC_ACQUIRE;
			end
			SYNC_ACQUIRE: begin
				prev = startup_cnt;
				startup_cnt = sat16(startup_cnt);
				if (prev >= reg_startup_wait) begin
					if (reg_dyn_offset) begin
						prev = owait_cnt;
						owait_cnt = sat16(owait_cnt);
						if (prev >= reg_offset_wait) begin
							offset_ns = seconds_to_ns(reg_default_sec);
							seq_phase = SYNC_WAIT;
						end else if (t.measured_offset_ok) begin
							offset_ns = t.measured_offset_ns;
							seq_phase = SYNC_WAIT;
						end
					end else begin
						offset_ns = seconds_to_ns(reg_static_sec);
						seq_phase = SYNC_WAIT;
					end
				end
			end
			SYNC_WAIT: begin
				period_cnt = sat16(period_cnt);
				if (period_cnt >= reg_sync_period) begin
					period_cnt = '0;
					if (t.time_base_valid || !reg_check_valid) begin
						pps_on = 1'b1;
						r.msg_valid = 1'b1;
						r.msg_time_ns = t.now_ns + offset_ns;
						for (int k = 0; k < 8; k++) begin
							r.msg_checksum = r.msg_checksum + r.msg_time_ns[8*k +: 8];
						end
						r.msg_sequence = seq_num;
						seq_num = seq_num + 8'd1;
						seq_phase = SYNC_SENT;
					end else begin
						seq_phase = SYNC_FAILED;
					end
				end
			end
			SYNC_SENT: begin
				pps_on = 1'b0;
				period_cnt = sat16(period_cnt);
				seq_phase = SYNC_WAIT;
			end
			SYNC_FAILED: begin
				seq_phase = SYNC_WAIT;
			end
			default: begin
			end
		endcase
		r.pps_level = pps_on ? reg_pps_level : !reg_pps_level;
		r.sync_state = seq_phase;
		r.active_offset_ns = offset_ns;
		return r;
	endfunction

	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 15);
		if (r < 12) begin
			return $urandom_range(1, 3);
		end else if (r < 15) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [63:0] random_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 64'h8000_0000_0000_0000;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [63:0] corner_word(int i);
		case (i)
			0: return 64'h0000_0000_0000_0000;
			1: return 64'hFFFF_FFFF_FFFF_FFFF;
			2: return 64'h8000_0000_0000_0000;
			3: return 64'h7FFF_FFFF_FFFF_FFFF;
			4: return 64'h00FF_00FF_00FF_00FF;
			5: return 64'hFF00_FF00_FF00_FF00;
			6: return 64'h5555_5555_5555_5555;
			7: return 64'hAAAA_AAAA_AAAA_AAAA;
			8: return 64'hFEDC_BA98_7654_3210;
			default: return 64'h0123_4567_89AB_CDEF;
		endcase
	endfunction

	function automatic tick_t random_tick(int unsigned ok_odds);
		tick_t t;
		t.time_base_valid = ($urandom_range(0, 7) != 0);
		t.now_ns = random_word();
		t.measured_offset_ok = ($urandom_range(0, ok_odds) == 0);
		t.measured_offset_ns = random_word();
		return t;
	endfunction

	task automatic queue_tick(tick_t t);
		pending_ticks.push_back(t);
		ticks_outstanding++;
	endtask

	task automatic write_register(cfg_idx_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			CFG_STARTUP_WAIT:   reg_startup_wait = val;
			CFG_OFFSET_WAIT:    reg_offset_wait = val;
			CFG_SYNC_PERIOD:    reg_sync_period = val;
			CFG_DYN_OFFSET_EN:  reg_dyn_offset = val[0];
			CFG_DEFAULT_OFFSET: reg_default_sec = val[11:0];
			CFG_STATIC_OFFSET:  reg_static_sec = val[11:0];
			CFG_PPS_LEVEL:      reg_pps_level = val[0];
			CFG_CHECK_VALID:    reg_check_valid = val[0];
			default: begin
			end
		endcase
	endtask

	task automatic settle_config();
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// The sender holds off here until every predicted result has been checked.
	task automatic wait_idle();
		do @(negedge clk); while (ticks_outstanding != 0 || results_due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	always @(posedge clk) begin : monitor
		result_t want;
		tick_fired = arst_n && tick_ch.valid && tick_ch.ready;
		if (tick_fired) begin
			results_due.push_back(advance_sequencer(tick_ch.data));
			ticks_outstanding--;
			if (gaps_on && $urandom_range(0, 2) == 0) begin
				tick_gap = gap_len();
			end
		end
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (results_due.size() == 0) begin
				$error("result item arrived with no prediction waiting");
				mismatches++;
			end else begin
				want = results_due.pop_front();
				if (result_ch.data.pps_level !== want.pps_level) begin
					$error("pps_level: expected %h, got %h", want.pps_level,
						result_ch.data.pps_level);
					mismatches++;
				end
				if (result_ch.data.msg_valid !== want.msg_valid) begin
					$error("msg_valid: expected %h, got %h", want.msg_valid,
						result_ch.data.msg_valid);
					mismatches++;
				end
				if (result_ch.data.msg_time_ns !== want.msg_time_ns) begin
					$error("msg_time_ns: expected %h, got %h", want.msg_time_ns,
						result_ch.data.msg_time_ns);
					mismatches++;
				end
				if (result_ch.data.msg_checksum !== want.msg_checksum) begin
					$error("msg_checksum: expected %h, got %h", want.msg_checksum,
						result_ch.data.msg_checksum);
					mismatches++;
				end
				if (result_ch.data.msg_sequence !== want.msg_sequence) begin
					$error("msg_sequence: expected %h, got %h", want.msg_sequence,
						result_ch.data.msg_sequence);
					mismatches++;
				end
				if (result_ch.data.sync_state !== want.sync_state) begin
					$error("sync_state: expected %h, got %h", want.sync_state,
						result_ch.data.sync_state);
					mismatches++;
				end
				if (result_ch.data.active_offset_ns !== want.active_offset_ns) begin
					$error("active_offset_ns: expected %h, got %h", want.active_offset_ns,
						result_ch.data.active_offset_ns);
					mismatches++;
				end
			end
		end
	end

	always @(negedge clk) begin : driver
		logic send;
		send = tick_ch.valid && !tick_fired;
		if (!send && arst_n) begin
			if (tick_gap > 0) begin
				tick_gap--;
			end else if (pending_ticks.size() > 0) begin
				tick_ch.data <= pending_ticks.pop_front();
				send = 1'b1;
			end
		end
		tick_ch.valid <= send;
		if (ready_stall > 0) begin
			result_ch.ready <= 1'b0;
			ready_stall--;
		end else begin
			result_ch.ready <= 1'b1;
			if (gaps_on && $urandom_range(0, 3) == 0) begin
				ready_stall = gap_len();
			end
		end
	end

	initial begin
		tick_t       d;
		logic [15:0] period;
		arst_n = 1'b0;
		tick_ch.valid = 1'b0;
		tick_ch.data = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_STARTUP_WAIT;
		cfg_ch.data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Acquisition settings; this is the only offset acquisition of the run.
		write_register(CFG_STARTUP_WAIT, ($urandom_range(0, 1) == 0) ? 16'd0 :
			16'($urandom_range(1, 10)));
		write_register(CFG_OFFSET_WAIT, ($urandom_range(0, 1) == 0) ? 16'd0 :
			16'($urandom_range(1, 10)));
		write_register(CFG_SYNC_PERIOD, 16'd0);
		write_register(CFG_DYN_OFFSET_EN, {15'($urandom), 1'($urandom_range(0, 1))});
		write_register(CFG_DEFAULT_OFFSET, {4'($urandom), 12'hFFF});
		write_register(CFG_STATIC_OFFSET, {4'($urandom), 12'hFFF});
		write_register(CFG_PPS_LEVEL, {15'($urandom), 1'b1});
		write_register(CFG_CHECK_VALID, {15'($urandom), 1'b1});
		settle_config();
		gaps_on = 1'b1;
		for (int i = 0; i < 28; i++) begin
			queue_tick(random_tick(5));
		end

		// Timestamp corners with wrapping sums, every third one without a valid time base.
		for (int i = 0; i < 10; i++) begin
			d.time_base_valid = (i % 3 != 2);
			d.now_ns = corner_word(i);
			d.measured_offset_ok = i[0];
			d.measured_offset_ns = corner_word(9 - i);
			queue_tick(d);
		end
		wait_idle();

		write_register(CFG_CHECK_VALID, {15'($urandom), 1'b0});
		write_register(CFG_PPS_LEVEL, {15'($urandom), 1'b0});
		write_register(CFG_SYNC_PERIOD, 16'd1);
		settle_config();
		for (int i = 0; i < 8; i++) begin
			d.time_base_valid = 1'b0;
			d.now_ns = corner_word(i + 1);
			d.measured_offset_ok = !i[0];
			d.measured_offset_ns = corner_word(i);
			queue_tick(d);
		end
		wait_idle();

		for (int ph = 0; ph < 8; ph++) begin
			case ($urandom_range(0, 9))
				0: period = 16'd0;
				1: period = 16'd1;
				8: period = 16'($urandom_range(13, 60));
				default: period = 16'($urandom_range(2, 12));
			endcase
			write_register(CFG_SYNC_PERIOD, period);
			write_register(CFG_PPS_LEVEL, 16'($urandom));
			write_register(CFG_CHECK_VALID, {15'($urandom), 1'($urandom_range(0, 3) != 0)});
			case (ph % 5)
				0: write_register(CFG_STARTUP_WAIT, 16'hFFFF);
				1: write_register(CFG_OFFSET_WAIT, 16'hFFFF);
				2: write_register(CFG_DYN_OFFSET_EN, 16'($urandom));
				3: write_register(CFG_DEFAULT_OFFSET, 16'($urandom));
				default: write_register(CFG_STATIC_OFFSET, 16'h0000);
			endcase
			settle_config();
			gaps_on = (ph % 4 != 3);
			for (int i = 0; i < 45; i++) begin
				queue_tick(random_tick(1));
			end
			wait_idle();
		end

		// Longest sync period at full rate; no sync fires within this short run.
		write_register(CFG_SYNC_PERIOD, 16'hFFFF);
		write_register(CFG_STARTUP_WAIT, 16'h0000);
		write_register(CFG_OFFSET_WAIT, 16'h0000);
		write_register(CFG_CHECK_VALID, {15'($urandom), 1'b1});
		settle_config();
		gaps_on = 1'b0;
		for (int i = 0; i < 40; i++) begin
			queue_tick(random_tick(1));
		end
		wait_idle();

		write_register(CFG_SYNC_PERIOD, 16'd2);
		write_register(CFG_PPS_LEVEL, {15'($urandom), 1'b1});
		settle_config();
		gaps_on = 1'b1;
		for (int i = 0; i < 40; i++) begin
			queue_tick(random_tick(1));
		end
		wait_idle();

		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/ptss_pkg.sv
rtl/ptss_ifs.sv
rtl/pps_time_sync_sequencer_unit.sv
bench/pps_time_sync_sequencer_unit_tb.sv
